// ===== hdl/cau_pkg.sv =====
// Shared types, constants and helper functions of the complex arithmetic unit.
package cau_pkg;

   localparam int FRAC_BITS        = 16;
   localparam int CORDIC_STEPS_DEF = 24;
   localparam int CNT_W            = 6;
   localparam int DIV_STEPS        = 32 + FRAC_BITS;
   localparam int SQRT_STEPS       = 32;
   localparam int MOD_STEPS        = 14;
   localparam int ARG_SHIFT        = 20;
   localparam int GAIN_SHIFT       = 8;
   localparam int POL_OUT_SHIFT    = 22;
   localparam int ANG_SHIFT        = 30 - FRAC_BITS;

   localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;

   localparam logic [3:0] MODE_ADD     = 4'd0;
   localparam logic [3:0] MODE_SUB     = 4'd1;
   localparam logic [3:0] MODE_MUL     = 4'd2;
   localparam logic [3:0] MODE_DIV     = 4'd3;
   localparam logic [3:0] MODE_CONJ    = 4'd4;
   localparam logic [3:0] MODE_POW     = 4'd5;
   localparam logic [3:0] MODE_MODULUS = 4'd6;
   localparam logic [3:0] MODE_ARG     = 4'd7;
   localparam logic [3:0] MODE_POLAR   = 4'd8;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DIVZERO = 2'd1;
   localparam logic [1:0] ST_NEGMOD  = 2'd2;
   localparam logic [1:0] ST_SAT     = 2'd3;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] a_re;
      logic signed [31:0] a_im;
      logic signed [31:0] b_re;
      logic signed [31:0] b_im;
      logic [5:0]         exponent;
   } req_type;

   typedef struct packed {
      logic signed [31:0] res_re;
      logic signed [31:0] res_im;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_ADDSUB, OP_MUL1, OP_MUL2, OP_MUL3,
      OP_DIVZERO, OP_NEGMOD, OP_DIV_P1, OP_DIV_P2, OP_DIV_P3, OP_DIV_P4,
      OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END, OP_SQ1, OP_SQ2, OP_SQRT_STEP,
      OP_SQRT_END, OP_ARG_INIT, OP_CORDIC_STEP, OP_ARG_END, OP_POL_INIT,
      OP_POL_MOD, OP_POL_RED, OP_POL_END
   } dp_op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_MUL1, S_MUL2, S_MUL3, S_DIV1, S_DIV2, S_DIV3,
      S_DIV4, S_DIV_INIT, S_DIV_STEP, S_DIV_END, S_SQ1, S_SQ2, S_SQRT_STEP,
      S_SQRT_END, S_ARG_INIT, S_CORDIC, S_ARG_END, S_POL_INIT, S_POL_MOD,
      S_POL_RED, S_POL_END, S_DONE
   } fsm_state_type;

   typedef struct packed {
      dp_op_type  op;
      logic [4:0] idx;
      logic       sel;
   } dp_cmd_type;

   typedef struct packed {
      logic [3:0] mode;
      logic [5:0] exponent;
      logic       b_zero;
      logic       a_zero;
      logic       a_neg;
   } dp_stat_type;

   typedef struct packed {
      logic               sat;
      logic signed [31:0] val;
   } pack_type;

   typedef struct packed {
      logic        neg;
      logic [65:0] mag;
   } smag_type;

   function automatic smag_type to_smag(input logic signed [65:0] v);
      smag_type r;
      r.neg = v[65];
      r.mag = v[65] ? 66'(-v) : 66'(v);
      return r;
   endfunction

   // clamp a sign and magnitude to the 32-bit range
   function automatic pack_type sat_pack(input logic neg, input logic [65:0] mag);
      pack_type r;
      r.sat = 1'b0;
      if (neg) begin
         if (mag > 66'h0_8000_0000) begin
            r.sat = 1'b1;
            r.val = 32'sh8000_0000;
         end else begin
            r.val = 32'(32'd0 - mag[31:0]);
         end
      end else begin
         if (mag > 66'h0_7FFF_FFFF) begin
            r.sat = 1'b1;
            r.val = 32'sh7FFF_FFFF;
         end else begin
            r.val = mag[31:0];
         end
      end
      return r;
   endfunction

   function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
      logic signed [35:0] r;
      case (i)
         5'd0: r = 36'sd843314857;
         5'd1: r = 36'sd497837829;
         5'd2: r = 36'sd263043837;
         5'd3: r = 36'sd133525159;
         5'd4: r = 36'sd67021687;
         5'd5: r = 36'sd33543516;
         5'd6: r = 36'sd16775851;
         5'd7: r = 36'sd8388437;
         5'd8: r = 36'sd4194283;
         5'd9: r = 36'sd2097149;
         5'd10: r = 36'sd1048576;
         5'd11: r = 36'sd524288;
         5'd12: r = 36'sd262144;
         5'd13: r = 36'sd131072;
         5'd14: r = 36'sd65536;
         5'd15: r = 36'sd32768;
         5'd16: r = 36'sd16384;
         5'd17: r = 36'sd8192;
         5'd18: r = 36'sd4096;
         5'd19: r = 36'sd2048;
         5'd20: r = 36'sd1024;
         5'd21: r = 36'sd512;
         5'd22: r = 36'sd256;
         5'd23: r = 36'sd128;
         5'd24: r = 36'sd64;
         5'd25: r = 36'sd32;
         5'd26: r = 36'sd16;
         5'd27: r = 36'sd8;
         5'd28: r = 36'sd4;
         5'd29: r = 36'sd2;
         5'd30: r = 36'sd1;
         default: r = 36'sd0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit on Q16.16 operands: top level joining sequencer and datapath.
//
// One item at a time: start is taken while busy is low, and the result appears
// on rsp_data for a single cycle with rsp_strobe high; it must be captured then.
// Add, subtract and conjugate are formed straight from the operands; multiply
// runs the multiplier states once and power once per exponent (not at all when
// exponent is 0); divide runs two 48-step restoring divisions sharing one
// remainder register, modulus a 32-step digit-by-digit root, argument the
// CORDIC loop of CORDIC_STEPS steps and polar a 14-step reduction of the angle
// modulo two pi, then the shared CORDIC loop. Divide by zero, a negative polar
// modulus, a zero argument operand and unused modes go from dispatch to the result.
module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   cau_ctrl #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

   cau_dp u_dp (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

// ===== hdl/cau_ctrl.sv =====
// Sequencer of the complex arithmetic unit: steps the datapath through each mode.
module cau_ctrl import cau_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_strobe,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   fsm_state_type    state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      sel_in     = sel_ff;
      cmd.op     = OP_NONE;
      cmd.idx    = cnt_ff[4:0];
      cmd.sel    = sel_ff;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.mode)
               MODE_ADD, MODE_SUB, MODE_CONJ: begin
                  cmd.op   = OP_ADDSUB;
                  state_in = S_DONE;
               end
               MODE_MUL: begin
                  cnt_in   = CNT_W'(1);
                  state_in = S_MUL1;
               end
               MODE_POW: begin
                  cnt_in   = CNT_W'(stat.exponent);
                  state_in = (stat.exponent == '0) ? S_DONE : S_MUL1;
               end
               MODE_DIV: begin
                  if (stat.b_zero) begin
                     cmd.op   = OP_DIVZERO;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_DIV1;
                  end
               end
               MODE_MODULUS: state_in = S_SQ1;
               MODE_ARG: state_in = stat.a_zero ? S_DONE : S_ARG_INIT;
               MODE_POLAR: begin
                  if (stat.a_neg) begin
                     cmd.op   = OP_NEGMOD;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_POL_INIT;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_MUL1: begin
            cmd.op   = OP_MUL1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.op   = OP_MUL2;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            cmd.op = OP_MUL3;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = S_MUL1;
            end
         end
         S_DIV1: begin
            cmd.op   = OP_DIV_P1;
            state_in = S_DIV2;
         end
         S_DIV2: begin
            cmd.op   = OP_DIV_P2;
            state_in = S_DIV3;
         end
         S_DIV3: begin
            cmd.op   = OP_DIV_P3;
            state_in = S_DIV4;
         end
         S_DIV4: begin
            cmd.op   = OP_DIV_P4;
            sel_in   = 1'b0;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = '0;
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_DIV_END;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_DIV_END: begin
            cmd.op = OP_DIV_END;
            if (!sel_ff) begin
               sel_in   = 1'b1;
               state_in = S_DIV_INIT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SQ1: begin
            cmd.op   = OP_SQ1;
            state_in = S_SQ2;
         end
         S_SQ2: begin
            cmd.op   = OP_SQ2;
            cnt_in   = '0;
            state_in = S_SQRT_STEP;
         end
         S_SQRT_STEP: begin
            cmd.op = OP_SQRT_STEP;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               state_in = S_SQRT_END;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_SQRT_END: begin
            cmd.op   = OP_SQRT_END;
            state_in = S_DONE;
         end
         S_ARG_INIT: begin
            cmd.op   = OP_ARG_INIT;
            cnt_in   = '0;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.op = OP_CORDIC_STEP;
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = (stat.mode == MODE_ARG) ? S_ARG_END : S_POL_END;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_ARG_END: begin
            cmd.op   = OP_ARG_END;
            state_in = S_DONE;
         end
         S_POL_INIT: begin
            cmd.op   = OP_POL_INIT;
            cnt_in   = CNT_W'(MOD_STEPS - 1);
            state_in = S_POL_MOD;
         end
         S_POL_MOD: begin
            // walk the multiples of two pi from the largest down
            cmd.op = OP_POL_MOD;
            if (cnt_ff == '0) begin
               state_in = S_POL_RED;
            end else begin
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_POL_RED: begin
            cmd.op   = OP_POL_RED;
            cnt_in   = '0;
            state_in = S_CORDIC;
         end
         S_POL_END: begin
            cmd.op   = OP_POL_END;
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== hdl/cau_dp.sv =====
// Datapath of the complex arithmetic unit: two multipliers, divider, root and CORDIC.
module cau_dp import cau_pkg::*; (
   input  logic        clock,
   input  req_type     req_data,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output rsp_type     rsp_data
);

   logic [3:0]         mode_ff, mode_in;
   logic signed [31:0] a_re_ff, a_re_in, a_im_ff, a_im_in;
   logic signed [31:0] b_re_ff, b_re_in, b_im_ff, b_im_in;
   logic [5:0]         exp_ff, exp_in;
   logic signed [31:0] res_re_ff, res_re_in, res_im_ff, res_im_in;
   logic               sat_ff, sat_in;
   logic [1:0]         st_ff, st_in;
   logic signed [63:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [63:0]        den_ff, den_in;
   logic [63:0]        num_re_ff, num_re_in, num_im_ff, num_im_in;
   logic               neg_re_ff, neg_re_in, neg_im_ff, neg_im_in;
   logic [63:0]        shr_ff, shr_in;
   logic [65:0]        rem_ff, rem_in;
   logic [47:0]        quo_ff, quo_in;
   logic               neg_ff, neg_in, ovf_ff, ovf_in, flip_ff, flip_in;
   logic signed [55:0] x_ff, x_in, y_ff, y_in;
   logic signed [35:0] z_ff, z_in;

   logic signed [31:0] m1a, m1b, m2a, m2b;
   logic signed [63:0] prod1, prod2;
   logic signed [65:0] sum_add, sum_sub;
   smag_type           sm_add, sm_sub;

   assign prod1   = m1a * m1b;
   assign prod2   = m2a * m2b;
   assign sum_add = 66'(p1_ff) + 66'(p2_ff);
   assign sum_sub = 66'(p1_ff) - 66'(p2_ff);
   assign sm_add  = to_smag(sum_add);
   assign sm_sub  = to_smag(sum_sub);

   assign stat.mode     = mode_ff;
   assign stat.exponent = exp_ff;
   assign stat.b_zero   = (b_re_ff == '0) && (b_im_ff == '0);
   assign stat.a_zero   = (a_re_ff == '0) && (a_im_ff == '0);
   assign stat.a_neg    = a_re_ff[31];

   assign rsp_data.res_re = res_re_ff;
   assign rsp_data.res_im = res_im_ff;
   assign rsp_data.status = (st_ff != ST_OK) ? st_ff : (sat_ff ? ST_SAT : ST_OK);

   // multiplier operand selection; power mode multiplies the running value by a
   always_comb begin
      m1a = '0;
      m1b = '0;
      m2a = '0;
      m2b = '0;
      case (cmd.op)
         OP_MUL1: begin
            m1a = res_re_ff;
            m1b = (mode_ff == MODE_POW) ? a_re_ff : b_re_ff;
            m2a = res_im_ff;
            m2b = (mode_ff == MODE_POW) ? a_im_ff : b_im_ff;
         end
         OP_MUL2: begin
            m1a = res_re_ff;
            m1b = (mode_ff == MODE_POW) ? a_im_ff : b_im_ff;
            m2a = res_im_ff;
            m2b = (mode_ff == MODE_POW) ? a_re_ff : b_re_ff;
         end
         OP_DIV_P1: begin
            m1a = b_re_ff;
            m1b = b_re_ff;
            m2a = b_im_ff;
            m2b = b_im_ff;
         end
         OP_DIV_P2: begin
            m1a = a_re_ff;
            m1b = b_re_ff;
            m2a = a_im_ff;
            m2b = b_im_ff;
         end
         OP_DIV_P3: begin
            m1a = a_im_ff;
            m1b = b_re_ff;
            m2a = a_re_ff;
            m2b = b_im_ff;
         end
         OP_SQ1: begin
            m1a = a_re_ff;
            m1b = a_re_ff;
            m2a = a_im_ff;
            m2b = a_im_ff;
         end
         OP_POL_INIT: begin
            m1a = a_re_ff;
            m1b = GAIN_Q30;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      pack_type           pk_re, pk_im;
      smag_type           sm_re, sm_im;
      logic [63:0]        dn;
      logic [64:0]        r65;
      logic [65:0]        r66, trial;
      logic signed [55:0] xs, ys, xi, yi, xf, yf;
      logic signed [35:0] at, zr;
      logic [47:0]        cmod;
      logic [32:0]        am;
      logic               dir;

      mode_in   = mode_ff;
      a_re_in   = a_re_ff;
      a_im_in   = a_im_ff;
      b_re_in   = b_re_ff;
      b_im_in   = b_im_ff;
      exp_in    = exp_ff;
      res_re_in = res_re_ff;
      res_im_in = res_im_ff;
      sat_in    = sat_ff;
      st_in     = st_ff;
      p1_in     = p1_ff;
      p2_in     = p2_ff;
      den_in    = den_ff;
      num_re_in = num_re_ff;
      num_im_in = num_im_ff;
      neg_re_in = neg_re_ff;
      neg_im_in = neg_im_ff;
      shr_in    = shr_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      neg_in    = neg_ff;
      ovf_in    = ovf_ff;
      flip_in   = flip_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;

      pk_re = '0;
      pk_im = '0;
      sm_re = '0;
      sm_im = '0;
      dn    = cmd.sel ? num_im_ff : num_re_ff;
      r65   = {rem_ff[63:0], shr_ff[63]};
      r66   = {rem_ff[63:0], shr_ff[63:62]};
      trial = {32'd0, quo_ff[31:0], 2'b01};
      xs    = x_ff >>> cmd.idx;
      ys    = y_ff >>> cmd.idx;
      at    = atan_q30(cmd.idx);
      xi    = 56'(a_re_ff) <<< ARG_SHIFT;
      yi    = 56'(a_im_ff) <<< ARG_SHIFT;
      xf    = flip_ff ? -x_ff : x_ff;
      yf    = flip_ff ? -y_ff : y_ff;
      zr    = neg_ff ? -36'(shr_ff[35:0]) : 36'(shr_ff[35:0]);
      cmod  = 48'(TWO_PI_Q30) << cmd.idx;
      am    = a_im_ff[31] ? -33'(a_im_ff) : 33'(a_im_ff);
      dir   = (mode_ff == MODE_ARG) ? (y_ff > 0) : z_ff[35];

      case (cmd.op)
         OP_LOAD: begin
            mode_in = req_data.mode;
            a_re_in = req_data.a_re;
            a_im_in = req_data.a_im;
            b_re_in = req_data.b_re;
            b_im_in = req_data.b_im;
            exp_in  = req_data.exponent;
            sat_in  = 1'b0;
            st_in   = ST_OK;
            res_im_in = '0;
            if (req_data.mode == MODE_MUL) begin
               res_re_in = req_data.a_re;
               res_im_in = req_data.a_im;
            end else if (req_data.mode == MODE_POW) begin
               res_re_in = 32'sd1 <<< FRAC_BITS;
            end else begin
               res_re_in = '0;
            end
         end
         OP_ADDSUB: begin
            case (mode_ff)
               MODE_ADD: begin
                  sm_re = to_smag(66'(a_re_ff) + 66'(b_re_ff));
                  sm_im = to_smag(66'(a_im_ff) + 66'(b_im_ff));
               end
               MODE_SUB: begin
                  sm_re = to_smag(66'(a_re_ff) - 66'(b_re_ff));
                  sm_im = to_smag(66'(a_im_ff) - 66'(b_im_ff));
               end
               default: begin
                  sm_re = to_smag(66'(a_re_ff));
                  sm_im = to_smag(-66'(a_im_ff));
               end
            endcase
            pk_re     = sat_pack(sm_re.neg, sm_re.mag);
            pk_im     = sat_pack(sm_im.neg, sm_im.mag);
            res_re_in = pk_re.val;
            res_im_in = pk_im.val;
            sat_in    = sat_ff | pk_re.sat | pk_im.sat;
         end
         OP_MUL1: begin
            p1_in = prod1;
            p2_in = prod2;
         end
         OP_MUL2: begin
            pk_re     = sat_pack(sm_sub.neg, sm_sub.mag >> FRAC_BITS);
            res_re_in = pk_re.val;
            sat_in    = sat_ff | pk_re.sat;
            p1_in     = prod1;
            p2_in     = prod2;
         end
         OP_MUL3: begin
            pk_im     = sat_pack(sm_add.neg, sm_add.mag >> FRAC_BITS);
            res_im_in = pk_im.val;
            sat_in    = sat_ff | pk_im.sat;
         end
         OP_DIVZERO: st_in = ST_DIVZERO;
         OP_NEGMOD:  st_in = ST_NEGMOD;
         OP_DIV_P1: begin
            p1_in = prod1;
            p2_in = prod2;
         end
         OP_DIV_P2: begin
            den_in = sum_add[63:0];
            p1_in  = prod1;
            p2_in  = prod2;
         end
         OP_DIV_P3: begin
            num_re_in = sm_add.mag[63:0];
            neg_re_in = sm_add.neg;
            p1_in     = prod1;
            p2_in     = prod2;
         end
         OP_DIV_P4: begin
            num_im_in = sm_sub.mag[63:0];
            neg_im_in = sm_sub.neg;
         end
         OP_DIV_INIT: begin
            rem_in = {34'd0, dn[63:32]};
            shr_in = {dn[31:0], 32'd0};
            ovf_in = {32'd0, dn[63:32]} >= den_ff;
            neg_in = cmd.sel ? neg_im_ff : neg_re_ff;
            quo_in = '0;
         end
         OP_DIV_STEP: begin
            shr_in = {shr_ff[62:0], 1'b0};
            if (r65 >= {1'b0, den_ff}) begin
               rem_in = 66'(r65 - {1'b0, den_ff});
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = 66'(r65);
               quo_in = {quo_ff[46:0], 1'b0};
            end
         end
         OP_DIV_END: begin
            pk_re = ovf_ff ? sat_pack(neg_ff, '1) : sat_pack(neg_ff, 66'(quo_ff));
            if (cmd.sel) begin
               res_im_in = pk_re.val;
            end else begin
               res_re_in = pk_re.val;
            end
            sat_in = sat_ff | pk_re.sat;
         end
         OP_SQ1: begin
            p1_in = prod1;
            p2_in = prod2;
         end
         OP_SQ2: begin
            shr_in = sum_add[63:0];
            rem_in = '0;
            quo_in = '0;
         end
         OP_SQRT_STEP: begin
            shr_in = {shr_ff[61:0], 2'b00};
            if (r66 >= trial) begin
               rem_in = r66 - trial;
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = r66;
               quo_in = {quo_ff[46:0], 1'b0};
            end
         end
         OP_SQRT_END: begin
            pk_re     = sat_pack(1'b0, 66'(quo_ff[31:0]));
            res_re_in = pk_re.val;
            res_im_in = '0;
            sat_in    = sat_ff | pk_re.sat;
         end
         OP_ARG_INIT: begin
            if (a_re_ff[31]) begin
               x_in = -xi;
               y_in = -yi;
               z_in = a_im_ff[31] ? -PI_Q30 : PI_Q30;
            end else begin
               x_in = xi;
               y_in = yi;
               z_in = '0;
            end
         end
         OP_CORDIC_STEP: begin
            if (dir) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end
         end
         OP_ARG_END: begin
            sm_re     = to_smag(66'((a_im_ff > 0) ? z_ff - TWO_PI_Q30 : z_ff));
            pk_re     = sat_pack(sm_re.neg, sm_re.mag >> ANG_SHIFT);
            res_re_in = pk_re.val;
            res_im_in = '0;
            sat_in    = sat_ff | pk_re.sat;
         end
         OP_POL_INIT: begin
            shr_in = 64'(am) << ANG_SHIFT;
            neg_in = a_im_ff[31];
            p1_in  = prod1;
         end
         OP_POL_MOD: begin
            if (shr_ff[47:0] >= cmod) begin
               shr_in = 64'(shr_ff[47:0] - cmod);
            end
         end
         OP_POL_RED: begin
            // fold the angle into one half turn around zero, flip the vector later
            if (zr > PI_Q30) begin
               zr = zr - TWO_PI_Q30;
            end
            if (zr < -PI_Q30) begin
               zr = zr + TWO_PI_Q30;
            end
            flip_in = 1'b0;
            if (zr > HALF_PI_Q30) begin
               zr      = zr - PI_Q30;
               flip_in = 1'b1;
            end else if (zr < -HALF_PI_Q30) begin
               zr      = zr + PI_Q30;
               flip_in = 1'b1;
            end
            z_in = zr;
            x_in = 56'(p1_ff >>> GAIN_SHIFT);
            y_in = '0;
         end
         OP_POL_END: begin
            sm_re     = to_smag(66'(xf));
            sm_im     = to_smag(66'(yf));
            pk_re     = sat_pack(sm_re.neg, sm_re.mag >> POL_OUT_SHIFT);
            pk_im     = sat_pack(sm_im.neg, sm_im.mag >> POL_OUT_SHIFT);
            res_re_in = pk_re.val;
            res_im_in = pk_im.val;
            sat_in    = sat_ff | pk_re.sat | pk_im.sat;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      a_re_ff   <= a_re_in;
      a_im_ff   <= a_im_in;
      b_re_ff   <= b_re_in;
      b_im_ff   <= b_im_in;
      exp_ff    <= exp_in;
      res_re_ff <= res_re_in;
      res_im_ff <= res_im_in;
      sat_ff    <= sat_in;
      st_ff     <= st_in;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      den_ff    <= den_in;
      num_re_ff <= num_re_in;
      num_im_ff <= num_im_in;
      neg_re_ff <= neg_re_in;
      neg_im_ff <= neg_im_in;
      shr_ff    <= shr_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
      ovf_ff    <= ovf_in;
      flip_ff   <= flip_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
   end

endmodule
